@@ rtl/core/dakf_pkg.sv @@
// ----------------------------------------------------------------------------
// dakf_pkg
// Shared widths, reset values, register codes and helpers of the dual-axis
// Kalman angle filter.
// ----------------------------------------------------------------------------
`default_nettype none

package dakf_pkg;

  localparam int unsigned ANG_W     = 26;   // signed Q10.16 angle / rate
  localparam int unsigned VAR_W     = 32;   // unsigned Q8.24 variance
  localparam int unsigned TS_W      = 24;   // unsigned Q0.24 time step
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 2;

  typedef logic signed [ANG_W-1:0] ang_t;
  typedef logic [VAR_W-1:0]        var_t;

  localparam ang_t ANG_MAX = ang_t'(33554431);
  localparam ang_t ANG_MIN = ang_t'(-33554432);

  localparam var_t            VAR_RESET = var_t'(67108864);   // 4.0
  localparam logic [TS_W-1:0] TS_RESET  = TS_W'(67109);       // 0.004 s
  localparam var_t            PN_RESET  = var_t'(4295);       // 0.000256
  localparam var_t            MN_RESET  = var_t'(150994944);  // 9.0

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIME_STEP  = 2'd0,
    CFG_PROC_NOISE = 2'd1,
    CFG_MEAS_NOISE = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [TS_W-1:0] time_step;
    var_t            process_noise;
    var_t            measurement_noise;
  } cfg_t;

  // lane -> merge stage
  typedef struct packed {
    logic done;
    ang_t est;
    var_t variance;
  } lane_res_t;

  function automatic ang_t sat_ang(input logic signed [63:0] x);
    ang_t r;
    if (x > 64'(ANG_MAX)) begin
      r = ANG_MAX;
    end else if (x < 64'(ANG_MIN)) begin
      r = ANG_MIN;
    end else begin
      r = x[ANG_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/dakf_in_if.sv @@
// ----------------------------------------------------------------------------
// dakf_in_if
// Input channel: one beat carries gyro rate and accel angle for both axes.
// ----------------------------------------------------------------------------
`default_nettype none

interface dakf_in_if;
  logic            valid;
  logic            ready;
  dakf_pkg::ang_t  roll_rate;
  dakf_pkg::ang_t  roll_angle;
  dakf_pkg::ang_t  pitch_rate;
  dakf_pkg::ang_t  pitch_angle;

  modport source (output valid, output roll_rate, output roll_angle,
                  output pitch_rate, output pitch_angle, input ready);
  modport sink   (input valid, input roll_rate, input roll_angle,
                  input pitch_rate, input pitch_angle, output ready);
endinterface

`default_nettype wire

@@ rtl/core/dakf_out_if.sv @@
// ----------------------------------------------------------------------------
// dakf_out_if
// Output channel: one beat carries estimate and variance for both axes.
// ----------------------------------------------------------------------------
`default_nettype none

interface dakf_out_if;
  logic            valid;
  logic            ready;
  dakf_pkg::ang_t  roll_estimate;
  dakf_pkg::var_t  roll_variance;
  dakf_pkg::ang_t  pitch_estimate;
  dakf_pkg::var_t  pitch_variance;

  modport source (output valid, output roll_estimate, output roll_variance,
                  output pitch_estimate, output pitch_variance, input ready);
  modport sink   (input valid, input roll_estimate, input roll_variance,
                  input pitch_estimate, input pitch_variance, output ready);
endinterface

`default_nettype wire

@@ rtl/core/dakf_div.sv @@
// ----------------------------------------------------------------------------
// dakf_div
// Restoring divider, one quotient bit per cycle: (num << GAIN_FRAC_BITS)/den
// with num <= den. Zero denominator gives zero.
// ----------------------------------------------------------------------------
`default_nettype none

module dakf_div #(
  parameter int unsigned GAIN_FRAC_BITS = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [dakf_pkg::VAR_W-1:0]   num_i,
  input  logic [dakf_pkg::VAR_W:0]     den_i,
  output logic                         done_o,
  output logic [GAIN_FRAC_BITS:0]      quo_o
);

  localparam int unsigned GW = GAIN_FRAC_BITS + 1;
  localparam int unsigned RW = dakf_pkg::VAR_W + 1;   // remainder / divisor
  localparam int unsigned CW = $clog2(GW);

  logic          busy_q, first_q, done_q, zero_q;
  logic [CW-1:0] cnt_q;
  logic [RW-1:0] rem_q, den_q, rem_d;
  logic [GW-1:0] quo_q;
  logic [RW:0]   sh, diff;
  logic          ge;

  always_comb begin
    sh    = first_q ? {1'b0, rem_q} : {rem_q, 1'b0};
    ge    = (sh >= {1'b0, den_q});
    diff  = sh - {1'b0, den_q};
    rem_d = ge ? diff[RW-1:0] : sh[RW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      first_q <= 1'b0;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q  <= 1'b1;
        first_q <= 1'b1;
        cnt_q   <= CW'(GAIN_FRAC_BITS);
      end else if (busy_q) begin
        first_q <= 1'b0;
        cnt_q   <= cnt_q - CW'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= {1'b0, num_i};
      den_q  <= den_i;
      zero_q <= (den_i == '0);
      quo_q  <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[GW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = zero_q ? '0 : quo_q;

endmodule

`default_nettype wire

@@ rtl/core/dakf_lane.sv @@
// ----------------------------------------------------------------------------
// dakf_lane
// One axis of the filter: predict, gain divide, correct. Holds the axis
// estimate and variance.
// ----------------------------------------------------------------------------
`default_nettype none

module dakf_lane #(
  parameter int unsigned GAIN_FRAC_BITS = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  dakf_pkg::ang_t       rate_i,
  input  dakf_pkg::ang_t       meas_i,
  input  dakf_pkg::cfg_t       cfg_i,
  output dakf_pkg::lane_res_t  res_o
);

  localparam int unsigned AW    = dakf_pkg::ANG_W;
  localparam int unsigned VW    = dakf_pkg::VAR_W;
  localparam int unsigned TW    = dakf_pkg::TS_W;
  localparam int unsigned GW    = GAIN_FRAC_BITS + 1;
  localparam int unsigned TSP_W = AW + TW + 1;          // rate * time_step
  localparam int unsigned INN_W = AW + 1;               // innovation
  localparam int unsigned CP_W  = GW + 1 + INN_W;       // gain * innovation
  localparam int unsigned VP_W  = VW + GW;              // var * (1 - gain)
  localparam int unsigned VS_W  = VP_W + 1 - GAIN_FRAC_BITS;

  localparam logic [TSP_W:0] TS_HALF = (TSP_W + 1)'(1) << (TW - 1);
  localparam logic [CP_W:0]  CP_HALF = (CP_W + 1)'(1) << (GAIN_FRAC_BITS - 1);
  localparam logic [VP_W:0]  VP_HALF = (VP_W + 1)'(1) << (GAIN_FRAC_BITS - 1);
  localparam logic [GW-1:0]  GAIN_ONE = GW'(1) << GAIN_FRAC_BITS;

  typedef enum logic [1:0] {L_IDLE, L_PRED, L_DIV, L_UPD} lane_state_e;

  lane_state_e            state_q;
  dakf_pkg::ang_t         est_q, meas_q, pred_q, pred_d, est_d;
  dakf_pkg::var_t         var_q, v_q, v_sat, var_d;
  logic                   done_q;
  logic signed [TSP_W-1:0] ts_prod_q, ts_prod_d;
  logic signed [CP_W-1:0]  corr_prod_q, corr_prod_d;
  logic [VP_W-1:0]         var_prod_q, var_prod_d;
  logic [VW:0]             v_sum, den_d;
  logic [TSP_W:0]          ts_rnd;
  logic [CP_W:0]           corr_rnd;
  logic [VP_W:0]           var_rnd;
  logic [VS_W-1:0]         var_shift;
  logic signed [INN_W-1:0] innov;
  logic [GW-1:0]           gain, keep;
  logic                    div_start, div_done;

  always_comb begin
    // prediction
    ts_prod_d = TSP_W'(rate_i) * TSP_W'($signed({1'b0, cfg_i.time_step}));
    v_sum     = {1'b0, var_q} + {1'b0, cfg_i.process_noise};
    v_sat     = v_sum[VW] ? '1 : v_sum[VW-1:0];
    ts_rnd    = (TSP_W + 1)'(ts_prod_q) + TS_HALF;
    pred_d    = dakf_pkg::sat_ang(64'(est_q) + 64'($signed(ts_rnd[TSP_W:TW])));
    den_d     = {1'b0, v_q} + {1'b0, cfg_i.measurement_noise};
    // correction
    innov       = INN_W'(meas_q) - INN_W'(pred_q);
    keep        = GAIN_ONE - gain;
    corr_prod_d = CP_W'($signed({1'b0, gain})) * CP_W'(innov);
    var_prod_d  = VP_W'(v_q) * VP_W'(keep);
    corr_rnd    = (CP_W + 1)'(corr_prod_q) + CP_HALF;
    est_d       = dakf_pkg::sat_ang(64'(pred_q) +
                                    64'($signed(corr_rnd[CP_W:GAIN_FRAC_BITS])));
    var_rnd     = (VP_W + 1)'(var_prod_q) + VP_HALF;
    var_shift   = var_rnd[VP_W:GAIN_FRAC_BITS];
    var_d       = (|var_shift[VS_W-1:VW]) ? '1 : var_shift[VW-1:0];
  end

  assign div_start = (state_q == L_PRED);

  dakf_div #(
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (v_q),
    .den_i  (den_d),
    .done_o (div_done),
    .quo_o  (gain)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      done_q  <= 1'b0;
      est_q   <= '0;
      var_q   <= dakf_pkg::VAR_RESET;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        L_IDLE: begin
          if (start_i) state_q <= L_PRED;
        end
        L_PRED: begin
          state_q <= L_DIV;
        end
        L_DIV: begin
          if (div_done) state_q <= L_UPD;
        end
        L_UPD: begin
          est_q   <= est_d;
          var_q   <= var_d;
          done_q  <= 1'b1;
          state_q <= L_IDLE;
        end
        default: state_q <= L_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == L_IDLE && start_i) begin
      ts_prod_q <= ts_prod_d;
      meas_q    <= meas_i;
      v_q       <= v_sat;
    end
    if (state_q == L_PRED) begin
      pred_q <= pred_d;
    end
    if (state_q == L_DIV && div_done) begin
      corr_prod_q <= corr_prod_d;
      var_prod_q  <= var_prod_d;
    end
  end

  assign res_o = '{done: done_q, est: est_q, variance: var_q};

endmodule

`default_nettype wire

@@ rtl/core/dual_axis_kalman_angle_filter_unit.sv @@
// Throughput: one beat at a time; next input beat taken once the result is
//   loaded into the output register.
// The gain divider in each lane is bit-serial (one quotient bit per cycle).
// Reset (rst_ni, async low): estimates 0, variances 4.0, registers to defaults.
// ----------------------------------------------------------------------------
// dual_axis_kalman_angle_filter_unit
// Roll/pitch 1-D Kalman angle filter: one lane per axis runs predict, gain
// divide and correct in parallel; a merge stage registers both results.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_axis_kalman_angle_filter_unit #(
  parameter int unsigned NUM_AXES       = 2,
  parameter int unsigned GAIN_FRAC_BITS = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // config write port
  input  logic                              cfg_we_i,
  input  logic [dakf_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [dakf_pkg::CFG_W-1:0]        cfg_data_i,
  // streams
  dakf_in_if.sink                           in_i,
  dakf_out_if.source                        out_o
);

  // The beat format has two axes; axes past NUM_AXES keep reset state.
  localparam int unsigned IO_AXES = 2;

  typedef enum logic [1:0] {T_IDLE, T_RUN, T_OUT} top_state_e;

  dakf_pkg::cfg_t       cfg_q;
  dakf_pkg::lane_res_t  res   [IO_AXES];
  dakf_pkg::ang_t       rate  [IO_AXES];
  dakf_pkg::ang_t       meas  [IO_AXES];
  logic [IO_AXES-1:0]   active, lane_done, done_seen_q;
  logic                 in_beat, all_done, can_load;
  top_state_e           state_q;
  logic                 out_valid_q;
  dakf_pkg::ang_t       roll_est_q, pitch_est_q;
  dakf_pkg::var_t       roll_var_q, pitch_var_q;

  // ---------------- configuration registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.time_step         <= dakf_pkg::TS_RESET;
      cfg_q.process_noise     <= dakf_pkg::PN_RESET;
      cfg_q.measurement_noise <= dakf_pkg::MN_RESET;
    end else if (cfg_we_i) begin
      unique case (dakf_pkg::cfg_idx_e'(cfg_idx_i))
        dakf_pkg::CFG_TIME_STEP:  cfg_q.time_step <= cfg_data_i[dakf_pkg::TS_W-1:0];
        dakf_pkg::CFG_PROC_NOISE: cfg_q.process_noise <= cfg_data_i;
        dakf_pkg::CFG_MEAS_NOISE: cfg_q.measurement_noise <= cfg_data_i;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // ---------------- lanes ----------------
  assign rate[0] = in_i.roll_rate;
  assign meas[0] = in_i.roll_angle;
  assign rate[1] = in_i.pitch_rate;
  assign meas[1] = in_i.pitch_angle;

  assign in_beat = in_i.valid & in_i.ready;

  for (genvar i = 0; i < IO_AXES; i++) begin : g_lane
    if (i < NUM_AXES) begin : g_on
      dakf_lane #(
        .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
      ) u_lane (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .start_i(in_beat),
        .rate_i (rate[i]),
        .meas_i (meas[i]),
        .cfg_i  (cfg_q),
        .res_o  (res[i])
      );
      assign active[i] = 1'b1;
    end else begin : g_off
      // axis not filtered: reports its reset state forever
      assign res[i]    = '{done: 1'b0, est: '0, variance: dakf_pkg::VAR_RESET};
      assign active[i] = 1'b0;
    end
    assign lane_done[i] = res[i].done;
  end

  // ---------------- merge stage ----------------
  // All lanes start on the same beat; wait until every active lane reports.
  assign all_done = &(done_seen_q | lane_done | ~active);
  assign can_load = (state_q == T_OUT) && (!out_valid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      done_seen_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // a new result replaces the one leaving in the same cycle
      if (can_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        T_IDLE: begin
          if (in_beat) begin
            done_seen_q <= '0;
            state_q     <= T_RUN;
          end
        end
        T_RUN: begin
          done_seen_q <= done_seen_q | lane_done;
          if (all_done) state_q <= T_OUT;
        end
        T_OUT: begin
          if (can_load) state_q <= T_IDLE;
        end
        default: state_q <= T_IDLE;
      endcase
    end
  end

  // result register: lane state is stable while we sit in T_OUT
  always_ff @(posedge clk_i) begin
    if (can_load) begin
      roll_est_q  <= res[0].est;
      roll_var_q  <= res[0].variance;
      pitch_est_q <= res[1].est;
      pitch_var_q <= res[1].variance;
    end
  end

  assign in_i.ready           = (state_q == T_IDLE);
  assign out_o.valid          = out_valid_q;
  assign out_o.roll_estimate  = roll_est_q;
  assign out_o.roll_variance  = roll_var_q;
  assign out_o.pitch_estimate = pitch_est_q;
  assign out_o.pitch_variance = pitch_var_q;

endmodule

`default_nettype wire
